@@ hw/rtl/projection_matrix_from_frustum_unit_defines.svh @@
// Assertion helpers shared by the projection unit RTL.
`ifndef PROJECTION_MATRIX_FROM_FRUSTUM_UNIT_DEFINES_SVH
`define PROJECTION_MATRIX_FROM_FRUSTUM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define PMFF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define PMFF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/pmff_pkg.sv @@
`default_nettype none
package pmff_pkg;

    localparam int NUM_W = 64;
    localparam int DEN_W = 33;
    localparam int QB    = 31;
    localparam int LANES = 6;

    localparam logic [1:0] KIND_ORTHO = 2'd0;
    localparam logic [1:0] KIND_PERSP = 2'd1;
    localparam logic [1:0] KIND_INF   = 2'd2;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
        logic signed [31:0] top;
        logic signed [31:0] near_plane;
        logic signed [31:0] far_or_epsilon;
    } item_t;

    typedef struct packed {
        logic               degenerate;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] depth_scale;
        logic signed [31:0] depth_offset;
    } result_t;

    // Operands of one quotient lane: unsigned dividend, divisor, result sign
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } lane_in_t;

    // State of one quotient lane after some number of restoring steps
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    low;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             sat;
        logic [QB-1:0]    quo;
    } qstage_t;

    // Values that bypass the quotient lanes
    typedef struct packed {
        logic               deg;
        logic               k2;
        logic signed [31:0] dsc;
        logic signed [31:0] doff;
    } side_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        begin
            m = v[32] ? (~v + 33'd1) : v;
            return m;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pmff_qdiv.sv @@
`default_nettype none
module pmff_qdiv
    import pmff_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire lane_in_t           lane_in,
    output logic signed [31:0]      quot
);

    qstage_t stage_reg  [0:QB];
    qstage_t stage_next [0:QB];
    logic [31:0] mag32;

    // Load: split dividend, flag a quotient that cannot fit 31 bits
    always_comb
    begin
        stage_next[0].rem = lane_in.num[NUM_W-1:QB];
        stage_next[0].low = lane_in.num[QB-1:0];
        stage_next[0].den = lane_in.den;
        stage_next[0].neg = lane_in.neg;
        stage_next[0].sat = (lane_in.num[NUM_W-1:QB] >= lane_in.den);
        stage_next[0].quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= stage_next[0];
        end
    end

    // One restoring step per stage: shift in a dividend bit, trial subtract
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {stage_reg[k-1].rem, stage_reg[k-1].low[QB-1]};
            diff  = trial - {1'b0, stage_reg[k-1].den};
            ge    = (trial >= {1'b0, stage_reg[k-1].den});
            stage_next[k].rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            stage_next[k].low = {stage_reg[k-1].low[QB-2:0], 1'b0};
            stage_next[k].den = stage_reg[k-1].den;
            stage_next[k].neg = stage_reg[k-1].neg;
            stage_next[k].sat = stage_reg[k-1].sat;
            stage_next[k].quo = {stage_reg[k-1].quo[QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        mag32 = {1'b0, stage_reg[QB].quo};
        if (stage_reg[QB].sat)
        begin
            quot = stage_reg[QB].neg ? Q_MIN : Q_MAX;
        end
        else
        begin
            quot = stage_reg[QB].neg ? $signed(~mag32 + 32'd1) : $signed(mag32);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/projection_matrix_from_frustum_unit.sv @@
`default_nettype none
// Projection matrix coefficients from a frustum: takes one frustum per clock while item_stall
// is low and returns the six non-trivial coefficients in signed fixed point with FRAC_BITS
// fraction bits, one result per transaction, in order. Throughput is one transaction per
// cycle while item_stall is low. Each transaction passes 36 registers: input register, two operand
// stages, the load stage plus 31 stages of the restoring quotient lanes (one quotient bit per
// stage, six lanes side by side), and the output register. A skid register behind the pipeline
// absorbs one result when result_stall is high; item_stall rises only while it is full.
`include "projection_matrix_from_frustum_unit_defines.svh"
module projection_matrix_from_frustum_unit
    import pmff_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam logic signed [32:0] ONE_Q = $signed(33'(64'd1 << FRAC_BITS));
    localparam logic signed [32:0] TWO_Q = $signed(33'(64'd2 << FRAC_BITS));
    localparam logic [31:0] ONE_OUT = 32'(64'd1 << FRAC_BITS);

    logic pipe_en;

    // Stage A: input register
    logic  a_vld_reg;
    item_t a_item_reg;

    // Stage B: differences, sums, degenerate test, n*f
    logic               b_vld_reg;
    logic signed [32:0] b_num_reg  [LANES];
    logic signed [32:0] b_den_reg  [LANES];
    logic signed [32:0] b_num_next [LANES];
    logic signed [32:0] b_den_next [LANES];
    logic               b_prod_reg, b_prod_next;
    logic [61:0]        b_nf_reg, b_nf_next;
    logic [32:0]        b_em_reg, b_em_next;
    logic               b_eneg_reg, b_eneg_next;
    logic [30:0]        b_n31_reg;
    logic signed [31:0] b_fm1_reg, b_fm1_next;
    logic               b_deg_reg, b_deg_next;
    logic               b_k2_reg;

    // Stage C: lane operands and the infinite-far product
    logic               c_vld_reg;
    lane_in_t           c_lane_reg  [LANES];
    lane_in_t           c_lane_next [LANES];
    logic [63:0]        c_pm_reg, c_pm_next;
    logic               c_eneg_reg;
    logic signed [31:0] c_fm1_reg;
    logic               c_deg_reg;
    logic               c_k2_reg;

    // Lane stages with their side values
    logic [QB:0]        vl_reg;
    side_t              sb_reg [0:QB];
    side_t              sb_next;
    logic signed [31:0] lane_q [LANES];

    // Output register and skid
    logic    res_vld_reg, res_vld_next;
    result_t res_data_reg, res_data_next;
    logic    skid_vld_reg, skid_vld_next;
    result_t skid_data_reg, skid_data_next;
    result_t fin;
    logic    push;
    logic    take;

    assign pipe_en    = !skid_vld_reg;
    assign item_stall = skid_vld_reg;

    // Advance valid bits while the skid is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            vl_reg    <= '0;
        end
        else if (pipe_en)
        begin
            a_vld_reg <= item_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            vl_reg    <= {vl_reg[QB-1:0], c_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_item_reg <= item;
        end
    end

    // Stage B: pick numerator and divisor of every lane by kind
    always_comb
    begin
        logic signed [32:0] l, r, b, t, n, f;
        logic signed [32:0] dx, ndx, dy, ndy, dz, sx, sy, sz, n2, e, ne, g;
        logic               ortho;
        l = {a_item_reg.left[31], a_item_reg.left};
        r = {a_item_reg.right[31], a_item_reg.right};
        b = {a_item_reg.bottom[31], a_item_reg.bottom};
        t = {a_item_reg.top[31], a_item_reg.top};
        n = {a_item_reg.near_plane[31], a_item_reg.near_plane};
        f = {a_item_reg.far_or_epsilon[31], a_item_reg.far_or_epsilon};
        dx  = r - l;
        ndx = l - r;
        dy  = t - b;
        ndy = b - t;
        dz  = n - f;
        sx  = r + l;
        sy  = t + b;
        sz  = n + f;
        n2  = n + n;
        e   = f - TWO_Q;
        ne  = TWO_Q - f;
        g   = f - ONE_Q;
        ortho = (a_item_reg.kind == KIND_ORTHO);

        // Equal bounds, bad planes, or an unused kind give the identity
        unique case (a_item_reg.kind)
            KIND_ORTHO: b_deg_next = (l == r) || (b == t) || (n == f);
            KIND_PERSP: b_deg_next = (l == r) || (b == t) || (n == f)
                                     || (n <= 0) || (f <= 0);
            KIND_INF:   b_deg_next = (l == r) || (b == t) || (n <= 0);
            default:    b_deg_next = 1'b1;
        endcase

        b_num_next[0] = ortho ? TWO_Q : n2;
        b_den_next[0] = dx;
        b_num_next[1] = ortho ? TWO_Q : n2;
        b_den_next[1] = dy;
        b_num_next[2] = sx;
        b_den_next[2] = ortho ? ndx : dx;
        b_num_next[3] = sy;
        b_den_next[3] = ortho ? ndy : dy;
        b_num_next[4] = ortho ? TWO_Q : sz;
        b_den_next[4] = dz;
        b_num_next[5] = sz;
        b_den_next[5] = dz;
        b_prod_next   = (a_item_reg.kind == KIND_PERSP);

        b_nf_next   = a_item_reg.near_plane[30:0] * a_item_reg.far_or_epsilon[30:0];
        b_em_next   = e[32] ? ne : e;
        b_eneg_next = e[32];
        if (g[32] != g[31])
        begin
            b_fm1_next = g[32] ? Q_MIN : Q_MAX;
        end
        else
        begin
            b_fm1_next = g[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            b_num_reg  <= b_num_next;
            b_den_reg  <= b_den_next;
            b_prod_reg <= b_prod_next;
            b_nf_reg   <= b_nf_next;
            b_em_reg   <= b_em_next;
            b_eneg_reg <= b_eneg_next;
            b_n31_reg  <= a_item_reg.near_plane[30:0];
            b_fm1_reg  <= b_fm1_next;
            b_deg_reg  <= b_deg_next;
            b_k2_reg   <= (a_item_reg.kind == KIND_INF);
        end
    end

    // Stage C: magnitudes, scale the dividend, form the result sign
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            c_lane_next[i].num = 64'(mag33(b_num_reg[i])) << FRAC_BITS;
            c_lane_next[i].den = mag33(b_den_reg[i]);
            c_lane_next[i].neg = b_num_reg[i][32] ^ b_den_reg[i][32];
        end
        // Perspective depth offset divides 2*n*f with no scaling
        if (b_prod_reg)
        begin
            c_lane_next[LANES-1].num = {1'b0, b_nf_reg, 1'b0};
            c_lane_next[LANES-1].neg = b_den_reg[LANES-1][32];
        end
        c_pm_next = b_em_reg * b_n31_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c_lane_reg <= c_lane_next;
            c_pm_reg   <= c_pm_next;
            c_eneg_reg <= b_eneg_reg;
            c_fm1_reg  <= b_fm1_reg;
            c_deg_reg  <= b_deg_reg;
            c_k2_reg   <= b_k2_reg;
        end
    end

    // Infinite-far depth offset: drop fraction bits, sign, saturate
    always_comb
    begin
        logic [63:0] ps;
        logic        big;
        ps  = c_pm_reg >> FRAC_BITS;
        big = |ps[63:31];
        sb_next.deg = c_deg_reg;
        sb_next.k2  = c_k2_reg;
        sb_next.dsc = c_fm1_reg;
        if (c_eneg_reg)
        begin
            sb_next.doff = big ? Q_MIN : $signed(~ps[31:0] + 32'd1);
        end
        else
        begin
            sb_next.doff = big ? Q_MAX : $signed(ps[31:0]);
        end
    end

    // Carry side values alongside the quotient lanes
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sb_reg[0] <= sb_next;
            for (int j = 1; j <= QB; j++)
            begin
                sb_reg[j] <= sb_reg[j-1];
            end
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        pmff_qdiv u_qdiv
        (
            .clk     (clk),
            .en      (pipe_en),
            .lane_in (c_lane_reg[i]),
            .quot    (lane_q[i])
        );
    end

    // Assemble the result; identity for a degenerate frustum
    always_comb
    begin
        if (sb_reg[QB].deg)
        begin
            fin.degenerate   = 1'b1;
            fin.scale_x      = $signed(ONE_OUT);
            fin.scale_y      = $signed(ONE_OUT);
            fin.offset_x     = '0;
            fin.offset_y     = '0;
            fin.depth_scale  = $signed(ONE_OUT);
            fin.depth_offset = '0;
        end
        else
        begin
            fin.degenerate   = 1'b0;
            fin.scale_x      = lane_q[0];
            fin.scale_y      = lane_q[1];
            fin.offset_x     = lane_q[2];
            fin.offset_y     = lane_q[3];
            fin.depth_scale  = sb_reg[QB].k2 ? sb_reg[QB].dsc : lane_q[4];
            fin.depth_offset = sb_reg[QB].k2 ? sb_reg[QB].doff : lane_q[5];
        end
    end

    // Output register with skid: hold a stalled transaction, park one more
    always_comb
    begin
        take           = res_vld_reg && !result_stall;
        push           = pipe_en && vl_reg[QB];
        res_vld_next   = res_vld_reg;
        res_data_next  = res_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        priority if (res_vld_reg && !take)
        begin
            if (push)
            begin
                skid_vld_next  = 1'b1;
                skid_data_next = fin;
            end
        end
        else if (skid_vld_reg)
        begin
            res_vld_next  = 1'b1;
            res_data_next = skid_data_reg;
            skid_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next  = push;
            res_data_next = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg  <= res_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg  <= res_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_data_reg;

    `PMFF_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, res_vld_reg, "skid full while output empty")
    `PMFF_ASSERT_NXT(a_skid_drains, skid_vld_reg && !result_stall, !skid_vld_reg, "skid did not drain")
    `PMFF_ASSERT_NXT(a_pipe_frozen, !pipe_en, $stable(vl_reg), "pipeline moved while frozen")
    `PMFF_ASSERT_IMP(a_identity, res_vld_reg && res_data_reg.degenerate, (res_data_reg.scale_x == $signed(ONE_OUT)) && (res_data_reg.offset_x == 32'sd0) && (res_data_reg.depth_offset == 32'sd0), "degenerate result is not identity")

endmodule
`default_nettype wire
